// ===== design/sdg_pkg.sv =====
`default_nettype none
package sdg_pkg;

  // Defaults for the top level parameters
  localparam int COEF_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF = 8;

  // Fixed field widths
  localparam int DIGIT_W       = 17;
  localparam int LEVEL_W       = 3;
  localparam int BASE_LOG_W    = 5;
  localparam int DIGIT_COUNT_W = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 5;

  localparam logic [BASE_LOG_W-1:0]    BASE_LOG_CAP    = BASE_LOG_W'(16);
  localparam logic [BASE_LOG_W-1:0]    BASE_LOG_RST    = BASE_LOG_W'(7);
  localparam logic [DIGIT_COUNT_W-1:0] DIGIT_COUNT_RST = DIGIT_COUNT_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_LOG    = 2'd0,
    REG_DIGIT_COUNT = 2'd1
  } cfg_reg_t;

  // One digit on its way to the output register, sign not yet applied
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               neg;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } digit_item_t;

endpackage
`default_nettype wire

// ===== design/sdg_coef_if.sv =====
`default_nettype none
interface sdg_coef_if
  import sdg_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface
`default_nettype wire

// ===== design/sdg_digit_if.sv =====
`default_nettype none
interface sdg_digit_if
  import sdg_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DIGIT_W-1:0] signed_digit;
  logic [LEVEL_W-1:0]        level;
  logic                      last_digit;

  modport source (output valid, output signed_digit, output level, output last_digit,
                  input ready);
  modport sink   (input valid, input signed_digit, input level, input last_digit,
                  output ready);
endinterface
`default_nettype wire

// ===== design/sdg_digit_gen.sv =====
`default_nettype none
module sdg_digit_gen
  import sdg_pkg::*;
#(
  parameter int XW    = 31,
  parameter int CNT_W = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  ld_valid,
  output logic                       ld_ready,
  input  wire logic [XW-1:0]         ld_mag,
  input  wire logic                  ld_neg,
  input  wire logic [BASE_LOG_W-1:0] bl,
  input  wire logic [CNT_W-1:0]      count,
  output logic                       dn_valid,
  input  wire logic                  dn_ready,
  output digit_item_t                dn_item
);

  // digit stage: holds the running magnitude
  logic              busy_r;
  logic [XW-1:0]     mag_r;
  logic              neg_r;
  logic [CNT_W-1:0]  lvl_r;
  // digit register
  logic              dv_r;
  digit_item_t       dig_r;

  logic [XW-1:0]      base_x, mask_x, low_x, half_x, mag_nxt;
  logic [DIGIT_W-1:0] base_d, low_d, digit_nxt;
  logic               up, is_last, s3_ready, emit, load;

  always_comb begin
    base_x    = XW'(1) << bl;
    mask_x    = base_x - XW'(1);
    half_x    = base_x >> 1;
    low_x     = mag_r & mask_x;
    up        = low_x > half_x;
    base_d    = DIGIT_W'(1) << bl;
    low_d     = {1'b0, low_x[DIGIT_W-2:0]};
    digit_nxt = up ? (low_d - base_d) : low_d;
    mag_nxt   = (mag_r >> bl) + XW'(up);
    is_last   = (lvl_r + CNT_W'(1)) == count;
    s3_ready  = !dv_r || dn_ready;
    emit      = busy_r && s3_ready;
    ld_ready  = !busy_r || (emit && is_last);
    load      = ld_valid && ld_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dv_r   <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && is_last) begin
        busy_r <= 1'b0;
      end
      if (s3_ready) begin
        dv_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag_r <= ld_mag;
      neg_r <= ld_neg;
      lvl_r <= '0;
    end else if (emit) begin
      mag_r <= mag_nxt;
      lvl_r <= lvl_r + CNT_W'(1);
    end
    if (emit) begin
      dig_r.digit <= digit_nxt;
      dig_r.neg   <= neg_r;
      dig_r.level <= LEVEL_W'(lvl_r);
      dig_r.last  <= is_last;
    end
  end

  assign dn_valid = dv_r;
  assign dn_item  = dig_r;

endmodule
`default_nettype wire

// ===== design/signed_gadget_decomposition.sv =====
`default_nettype none
// Channel   Dir  Payload                                 Transaction
// in_ch     in   coefficient (COEF_WIDTH, signed)         one per coefficient
// out_ch    out  signed_digit (17, signed), level, last   one per digit
// cfg_*     in   cfg_index, cfg_wdata                     one per cfg_we cycle
//
// Digits: max(1, min(digit_count, MAX_DIGITS)) per coefficient; the generator
// emits one digit per cycle unless out_ch stalls, taking the next coefficient
// in the cycle of the last digit. Path: stage 1, sequencer, digit, output regs.
// Reset: synchronous, active low; base_log = 7, digit_count = 3, pipe empty.
// Stalls: out_ch.ready low holds the output register; backpressure ripples
// up stage by stage, nothing dropped or repeated.
module signed_gadget_decomposition
  import sdg_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sdg_coef_if.sink                   in_ch,
  sdg_digit_if.source                out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int MW    = COEF_WIDTH - 1;                 // magnitude bits
  localparam int XW    = (MW > DIGIT_W) ? MW : DIGIT_W;  // working width
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  // config registers
  logic [BASE_LOG_W-1:0]    base_log_r;
  logic [DIGIT_COUNT_W-1:0] digit_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_log_r    <= BASE_LOG_RST;
      digit_count_r <= DIGIT_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_LOG:    base_log_r    <= cfg_wdata[BASE_LOG_W-1:0];
        REG_DIGIT_COUNT: digit_count_r <= cfg_wdata[DIGIT_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated config
  logic [BASE_LOG_W-1:0] bl_sat;
  logic [CNT_W-1:0]      count_sat;

  always_comb begin
    bl_sat = (base_log_r > BASE_LOG_CAP) ? BASE_LOG_CAP : base_log_r;
    if (digit_count_r == '0) begin
      count_sat = CNT_W'(1);
    end else if (32'(digit_count_r) > MAX_DIGITS) begin
      count_sat = CNT_W'(MAX_DIGITS);
    end else begin
      count_sat = CNT_W'(digit_count_r);
    end
  end

  // stage 1: magnitude and sign; most negative value clamps to max magnitude
  logic                  s1_v_r;
  logic [XW-1:0]         s1_mag_r;
  logic                  s1_neg_r;
  logic                  s1_ready, ld_ready;
  logic [COEF_WIDTH-1:0] coef_u, coef_negd;
  logic [MW-1:0]         mag_in;
  logic                  neg_in;

  always_comb begin
    coef_u    = in_ch.coefficient;
    neg_in    = coef_u[COEF_WIDTH-1];
    coef_negd = ~coef_u + COEF_WIDTH'(1);
    if (!neg_in) begin
      mag_in = coef_u[MW-1:0];
    end else if (coef_negd[COEF_WIDTH-1]) begin
      mag_in = '1;
    end else begin
      mag_in = coef_negd[MW-1:0];
    end
  end

  assign s1_ready    = !s1_v_r || ld_ready;
  assign in_ch.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_ch.valid) begin
      s1_mag_r <= XW'(mag_in);
      s1_neg_r <= neg_in;
    end
  end

  // stages 2 and 3: digit sequencer and digit register
  logic        dn_valid, dn_ready;
  digit_item_t dn_item;

  sdg_digit_gen #(
    .XW    (XW),
    .CNT_W (CNT_W)
  ) u_digit_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_valid (s1_v_r),
    .ld_ready (ld_ready),
    .ld_mag   (s1_mag_r),
    .ld_neg   (s1_neg_r),
    .bl       (bl_sat),
    .count    (count_sat),
    .dn_valid (dn_valid),
    .dn_ready (dn_ready),
    .dn_item  (dn_item)
  );

  // stage 4: sign applied, output register
  logic               o_v_r;
  logic [DIGIT_W-1:0] o_digit_r;
  logic [LEVEL_W-1:0] o_level_r;
  logic               o_last_r;

  assign dn_ready = !o_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (dn_ready) begin
      o_v_r <= dn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dn_ready && dn_valid) begin
      o_digit_r <= dn_item.neg ? (~dn_item.digit + DIGIT_W'(1)) : dn_item.digit;
      o_level_r <= dn_item.level;
      o_last_r  <= dn_item.last;
    end
  end

  assign out_ch.valid        = o_v_r;
  assign out_ch.signed_digit = o_digit_r;
  assign out_ch.level        = o_level_r;
  assign out_ch.last_digit   = o_last_r;

endmodule
`default_nettype wire

// ===== dv/tb_signed_gadget_decomposition.sv =====
`timescale 1ns / 1ps

module tb_signed_gadget_decomposition
  import sdg_pkg::*;
();

  localparam int COEF_W         = COEF_WIDTH_DEF;
  localparam int PHASE_ITEMS    = 24;
  localparam int FIXED_PHASES   = 12;
  localparam int RANDOM_PHASES  = 3;
  localparam int DRAIN_CYCLES   = 8;     // spare cycles after the last expected digit
  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up

  // Index codes the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  typedef struct packed {
    logic signed [DIGIT_W-1:0] signed_digit;
    logic [LEVEL_W-1:0]        level;
    logic                      last_digit;
  } digit_result_t;

  // Digit predictor and in-order checker. Holds its own copy of the two
  // registers, mirrored on every write the driver issues.
  class digit_scoreboard;
    logic [BASE_LOG_W-1:0]    base_log;
    logic [DIGIT_COUNT_W-1:0] digit_count;
    digit_result_t            expected_digits[$];
    int                       mismatches;

    function new();
      base_log    = BASE_LOG_RST;
      digit_count = DIGIT_COUNT_RST;
      mismatches  = 0;
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatches++;
    endtask

    function void set_register(input logic [CFG_IDX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] data);
      if (index == REG_BASE_LOG) begin
        base_log = data[BASE_LOG_W-1:0];
      end else if (index == REG_DIGIT_COUNT) begin
        digit_count = data[DIGIT_COUNT_W-1:0];
      end
    endfunction

    function int pending();
      return expected_digits.size();
    endfunction

    // Balanced split of |coefficient|, sign put back on every digit
    function void note_coefficient(input logic signed [COEF_W-1:0] coefficient);
      logic [COEF_W-1:0] neg_raw;
      logic [63:0]       mag;
      logic [63:0]       low;
      logic [63:0]       base;
      logic [63:0]       mask;
      logic [63:0]       half;
      logic [63:0]       d;
      logic              negative;
      int unsigned       shift;
      int unsigned       count;
      digit_result_t     r;
      negative = coefficient[COEF_W-1];
      if (negative) begin
        neg_raw = ~coefficient + 1'b1;
        mag     = 64'(neg_raw);
        // most negative value: magnitude saturates one step down
        if (mag == (64'd1 << (COEF_W - 1))) mag = (64'd1 << (COEF_W - 1)) - 64'd1;
      end else begin
        mag = 64'(coefficient);
      end
      shift = (base_log > BASE_LOG_CAP) ? BASE_LOG_CAP : base_log;
      count = digit_count;
      if (count < 1) count = 1;
      if (count > MAX_DIGITS_DEF) count = MAX_DIGITS_DEF;
      base = 64'd1 << shift;
      mask = base - 64'd1;
      half = base >> 1;
      for (int unsigned j = 0; j < count; j++) begin
        low = mag & mask;
        if (low > half) begin
          d   = low - base;
          mag = (mag >> shift) + 64'd1;
        end else begin
          d   = low;
          mag = mag >> shift;
        end
        if (negative) d = ~d + 64'd1;
        r.signed_digit = d[DIGIT_W-1:0];
        r.level        = j[LEVEL_W-1:0];
        r.last_digit   = (j + 1 == count);
        expected_digits.insert(expected_digits.size(), r);
      end
    endfunction

    task check_digit(input digit_result_t got);
      digit_result_t want;
      if (expected_digits.size() == 0) begin
        report_mismatch($sformatf("digit %0d level %0d with nothing expected",
                                  got.signed_digit, got.level));
        return;
      end
      want = expected_digits.pop_front();
      if (got.signed_digit !== want.signed_digit)
        report_mismatch($sformatf("level %0d: signed_digit %0d, expected %0d",
                                  want.level, got.signed_digit, want.signed_digit));
      if (got.level !== want.level)
        report_mismatch($sformatf("level %0d, expected %0d", got.level, want.level));
      if (got.last_digit !== want.last_digit)
        report_mismatch($sformatf("level %0d: last_digit %0b, expected %0b",
                                  want.level, got.last_digit, want.last_digit));
    endtask
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_wdata;
  bit                       steady;        // phase with no idling on either side
  int                       quiet_cycles;
  digit_scoreboard          sb = new();

  sdg_coef_if #(.COEF_WIDTH(COEF_W)) coef_ch ();
  sdg_digit_if                       digit_ch ();

  signed_gadget_decomposition #(
    .COEF_WIDTH (COEF_W),
    .MAX_DIGITS (MAX_DIGITS_DEF)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (coef_ch),
    .out_ch    (digit_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Coefficient mix. The digit-pattern branch builds magnitudes level by
  // level from 0, B/2, B/2+1, B-1 and random digits, so the carry and the
  // half-base tie get hit often for whatever base is set.
  function automatic logic signed [COEF_W-1:0] random_coefficient(input int unsigned bl);
    logic [63:0]              m;
    logic [63:0]              b;
    logic [63:0]              pick;
    logic signed [COEF_W-1:0] value;
    case ($urandom_range(0, 5))
      0, 1: begin
        value = $urandom;
      end
      2: begin
        m = 64'd0;
        b = 64'd1 << bl;
        for (int unsigned j = 0; j < 8; j++) begin
          case ($urandom_range(0, 4))
            0:       pick = 64'd0;
            1:       pick = b >> 1;
            2:       pick = (b >> 1) + 64'd1;
            3:       pick = b - 64'd1;
            default: pick = 64'($urandom) & (b - 64'd1);
          endcase
          m = m | (pick << (j * bl));
        end
        if (bl == 0) m = 64'($urandom_range(0, 1000));
        value = {1'b0, m[COEF_W-2:0]};
        if ($urandom_range(0, 1) != 0) value = -value;
      end
      3: begin
        case ($urandom_range(0, 5))
          0:       value = 32'h7FFF_FFFF;
          1:       value = 32'h8000_0000;
          2:       value = 32'h8000_0001;
          3:       value = 32'h0000_0000;
          4:       value = 32'h0000_0001;
          default: value = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        value = $urandom_range(0, 1 << 20);
        if ($urandom_range(0, 1) != 0) value = -value;
      end
    endcase
    return value;
  endfunction

  // All TB drive happens at posedge and the block only moves at posedge, so
  // the channels are stable at negedge: a valid&&ready seen there is exactly
  // the transaction the next rising edge takes.
  always @(negedge clk) begin
    if (rst_n) begin
      if ((coef_ch.valid && coef_ch.ready) || (digit_ch.valid && digit_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (digit_ch.valid && digit_ch.ready)
        sb.check_digit('{signed_digit: digit_ch.signed_digit,
                         level:        digit_ch.level,
                         last_digit:   digit_ch.last_digit});
    end
  end

  initial begin
    quiet_cycles = 0;
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
    $display("signed_gadget_decomposition regression: fail");
    $finish;
  end

  // Digit sink: random ready with stalls; held high in steady phases.
  initial begin
    int unsigned span;
    digit_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (steady || $urandom_range(0, 2) != 0) begin
        digit_ch.ready <= 1'b1;
        span = $urandom_range(1, 12);
      end else begin
        digit_ch.ready <= 1'b0;
        span = idle_length();
        if (span == 0) span = 1;
      end
      repeat (span - 1) @(posedge clk);
    end
  end

  // Offer one coefficient, optionally after an idle gap. Returns on the
  // accepting edge with valid still high, so a back-to-back call keeps it up.
  task automatic send_coefficient(input logic signed [COEF_W-1:0] coefficient);
    int unsigned gap;
    gap = steady ? 0 : idle_length();
    if (gap != 0) begin
      coef_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coef_ch.valid       <= 1'b1;
    coef_ch.coefficient <= coefficient;
    do @(negedge clk); while (!coef_ch.ready);
    @(posedge clk);
    sb.note_coefficient(coefficient);
  endtask

  // Drop valid, let every expected digit come out, then a few spare cycles.
  task automatic wait_drained();
    coef_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write of a batch.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_register(index, data);
  endtask

  // Main sequence: reset, directed coefficients at the reset setting, then
  // phases of random coefficients, each under a new register setting.
  initial begin
    logic signed [COEF_W-1:0]  directed[12];
    logic [CFG_DATA_W-1:0]     phase_base_log[FIXED_PHASES];
    logic [CFG_DATA_W-1:0]     phase_digit_count[FIXED_PHASES];
    logic [CFG_DATA_W-1:0]     bl_value;
    logic [CFG_DATA_W-1:0]     dc_value;
    int unsigned               eff_bl;

    // Base 7 / 3 digits: zero, unit, half-base tie and carry on both signs,
    // top of range, and the most negative value that saturates.
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd64, 32'sd65, -32'sd64, -32'sd65,
                 32'sd127, 32'sd128, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000};
    // Extremes: base 1 and 16, base 0, base above the cap, digit count 0,
    // above the maximum, and a write with the upper data bit set (19 -> 3).
    phase_base_log    = '{5'd1, 5'd16, 5'd0, 5'd17, 5'd31, 5'd5,
                          5'd4, 5'd2,  5'd16, 5'd8, 5'd3,  5'd12};
    phase_digit_count = '{5'd1, 5'd8,  5'd3, 5'd8,  5'd15, 5'd0,
                          5'd9, 5'd8,  5'd1,  5'd19, 5'd4, 5'd6};

    steady              = 1'b0;
    rst_n               <= 1'b0;
    coef_ch.valid       <= 1'b0;
    coef_ch.coefficient <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_BASE_LOG;
    cfg_wdata           <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_coefficient(directed[i]);

    for (int p = 0; p < FIXED_PHASES + RANDOM_PHASES; p++) begin
      wait_drained();
      if (p < FIXED_PHASES) begin
        bl_value = phase_base_log[p];
        dc_value = phase_digit_count[p];
      end else begin
        bl_value = $urandom_range(0, 31);
        dc_value = $urandom_range(0, 31);
      end
      write_register(REG_BASE_LOG, bl_value);
      write_register(REG_DIGIT_COUNT, dc_value);
      // unmapped index must leave both registers alone
      write_register((p % 2 == 0) ? REG_UNUSED_A : REG_UNUSED_B, CFG_DATA_W'($urandom));
      cfg_we <= 1'b0;

      steady = (p % 4 == 3);
      eff_bl = (sb.base_log > BASE_LOG_CAP) ? BASE_LOG_CAP : sb.base_log;
      for (int n = 0; n < PHASE_ITEMS; n++) send_coefficient(random_coefficient(eff_bl));
    end

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("signed_gadget_decomposition regression: pass");
    end else begin
      $display("signed_gadget_decomposition regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sdg_pkg.sv
design/sdg_coef_if.sv
design/sdg_digit_if.sv
design/sdg_digit_gen.sv
design/signed_gadget_decomposition.sv
dv/tb_signed_gadget_decomposition.sv
